// ----- src/tdpc_pkg.sv -----
package tdpc_pkg;

	localparam int NUM_W = 24;
	localparam int CNT_W = 21;
	localparam int DIV_CNT_W = $clog2(NUM_W + 1);

	localparam logic [NUM_W-1:0] FIRST_PRIME = NUM_W'(2);
	localparam logic [NUM_W-1:0] FIRST_ODD_DIVISOR = NUM_W'(3);

	typedef struct packed {
		logic             kind;
		logic [NUM_W-1:0] number;
	} req_t;

	typedef struct packed {
		logic             is_prime;
		logic [CNT_W-1:0] prime_count;
	} rsp_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] dividend;
		logic [NUM_W-1:0] divisor;
	} div_cmd_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quot;
		logic [NUM_W-1:0] rem;
	} div_res_t;

endpackage

// ----- src/tdpc_div.sv -----
module tdpc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tdpc_pkg::div_cmd_t cmd,
	output tdpc_pkg::div_res_t res
);
	import tdpc_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0]     rem_q;
	logic [NUM_W-1:0]     quo_q;
	logic [NUM_W-1:0]     dvs_q;
	logic [NUM_W:0]       rem_shift;
	logic [NUM_W:0]       diff;

	// One restoring step per cycle: shift in the next dividend bit and try the subtract.
	assign rem_shift = {rem_q, quo_q[NUM_W-1]};
	assign diff      = rem_shift - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !cmd.start && busy_q && (cnt_q == DIV_CNT_W'(NUM_W - 1));
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= '0;
			quo_q <= cmd.dividend;
			dvs_q <= cmd.divisor;
		end else if (busy_q) begin
			if (!diff[NUM_W]) begin
				rem_q <= diff[NUM_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_shift[NUM_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign res.done = done_q;
	assign res.quot = quo_q;
	assign res.rem  = rem_q;

endmodule

// ----- src/trial_division_prime_counter.sv -----
// Test mode: values below 2 or even are settled without the divider; otherwise
// odd trial divisors from 3 upward are tried, about sqrt(number)/2 divisors.
// Count mode repeats that test for every candidate from 2 to number, each also passing ST_CHECK and ST_FIN.
// The single bit-serial divider does every trial division; one request is worked at a time.
// Reset clears the sequencer and the result valid; no memory needs clearing.
module trial_division_prime_counter (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  tdpc_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output tdpc_pkg::rsp_t rsp
);
	import tdpc_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]       state_q;
	logic             kind_q;
	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] cand_q;
	logic [NUM_W-1:0] d_q;
	logic [CNT_W-1:0] cnt_q;
	logic             verdict_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	div_cmd_t         div_cmd;
	div_res_t         div_res;
	logic             trivial;
	logic             trivial_prime;
	logic             div_prime;
	logic             div_comp;
	logic             out_free;

	tdpc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.res    (div_res)
	);

	assign trivial       = (cand_q < FIRST_PRIME) || !cand_q[0];
	assign trivial_prime = (cand_q == FIRST_PRIME);
	// Once the divisor passes the quotient, no factor up to the square root exists.
	assign div_prime     = div_res.done && (d_q > div_res.quot);
	assign div_comp      = div_res.done && !div_prime && (div_res.rem == '0);
	assign out_free      = !rsp_valid_q || !rsp_stall;

	always_comb begin
		div_cmd.dividend = cand_q;
		div_cmd.divisor  = FIRST_ODD_DIVISOR;
		div_cmd.start    = 1'b0;
		if (state_q == ST_CHECK) begin
			div_cmd.start = !trivial && !trivial_prime;
		end else if (state_q == ST_DIV) begin
			div_cmd.divisor = d_q + NUM_W'(2);
			div_cmd.start   = div_res.done && !div_prime && !div_comp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && !(kind_q && cand_q < num_q) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= (req.kind && req.number < FIRST_PRIME) ? ST_FIN : ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (trivial || trivial_prime) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_prime || div_comp) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (kind_q && cand_q < num_q) begin
						state_q <= ST_CHECK;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				kind_q    <= req.kind;
				num_q     <= req.number;
				cand_q    <= req.kind ? FIRST_PRIME : req.number;
				cnt_q     <= '0;
				verdict_q <= 1'b0;
			end
			ST_CHECK: begin
				d_q       <= FIRST_ODD_DIVISOR;
				verdict_q <= trivial_prime;
				if (trivial_prime) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			ST_DIV: begin
				if (div_cmd.start) begin
					d_q <= div_cmd.divisor;
				end
				if (div_prime) begin
					verdict_q <= 1'b1;
					cnt_q     <= cnt_q + 1'b1;
				end else if (div_comp) begin
					verdict_q <= 1'b0;
				end
			end
			ST_FIN: begin
				if (kind_q && cand_q < num_q) begin
					cand_q <= cand_q + 1'b1;
				end else if (out_free) begin
					rsp_q.is_prime    <= verdict_q;
					rsp_q.prime_count <= kind_q ? cnt_q : '0;
				end
			end
			default: begin
				cand_q <= cand_q;
			end
		endcase
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == ST_DIV)
		else $error("divider finished outside of a division step");

	a_cand_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && kind_q && num_q >= FIRST_PRIME) |-> cand_q <= num_q)
		else $error("count candidate ran past the limit");

	a_divisor_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (d_q[0] && d_q >= FIRST_ODD_DIVISOR))
		else $error("trial divisor is not an odd value of at least three");

	a_test_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) && !kind_q |-> rsp_q.prime_count == '0)
		else $error("test mode request returned a nonzero count");

endmodule
